// ----- rtl/pbfe_pkg.sv -----
// Shared types and constants for the protobuf field encoder.
// No dependencies; used by every module in rtl/.
package pbfe_pkg;

    localparam int unsigned KIND_W  = 4;
    localparam int unsigned FNUM_W  = 29;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned KEY_W   = 32;
    localparam int unsigned CNT_W   = 4;

    // item kinds
    localparam logic [KIND_W-1:0] K_UVARINT = 4'd0;
    localparam logic [KIND_W-1:0] K_SINT8   = 4'd1;
    localparam logic [KIND_W-1:0] K_SINT16  = 4'd2;
    localparam logic [KIND_W-1:0] K_SINT32  = 4'd3;
    localparam logic [KIND_W-1:0] K_SINT64  = 4'd4;
    localparam logic [KIND_W-1:0] K_FIXED32 = 4'd5;
    localparam logic [KIND_W-1:0] K_FIXED64 = 4'd6;
    localparam logic [KIND_W-1:0] K_LENHDR  = 4'd7;
    localparam logic [KIND_W-1:0] K_PAYLOAD = 4'd8;

    // wire types
    localparam logic [2:0] WT_VARINT   = 3'd0;
    localparam logic [2:0] WT_FIXED64  = 3'd1;
    localparam logic [2:0] WT_LENDELIM = 3'd2;
    localparam logic [2:0] WT_FIXED32  = 3'd5;

    localparam logic [6:0] VARINT_MASK = 7'h7f;
    localparam logic [7:0] VARINT_MORE = 8'h80;

    localparam logic [CNT_W-1:0] CNT_ONE   = 4'd1;
    localparam logic [CNT_W-1:0] CNT_FOUR  = 4'd4;
    localparam logic [CNT_W-1:0] CNT_EIGHT = 4'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KEY,
        ST_VAL
    } t_state;

    // load mode for a digit shifter
    typedef struct packed {
        logic             raw;    // 1: plain bytes, 0: base-128 varint
        logic [CNT_W-1:0] count;  // byte count in raw mode
    } t_sr_mode;

    // what a digit shifter presents
    typedef struct packed {
        logic [7:0] digit;
        logic       done;   // current digit is the final one
    } t_sr_stat;

endpackage

// ----- rtl/protobuf_field_encoder_core.sv -----
// Protobuf field encoder: top level with sequencer and output register.
// Depends on pbfe_pkg and pbfe_digit_sr.
//
// Usage:
//   Input channel (i_valid / o_stall) takes one item: kind, field number and
//   a 64-bit value. Output channel (o_valid / i_stall) delivers the encoded
//   bytes one per item, in stream order, with o_last on the final byte of the
//   run caused by that input item.
//   The key is loaded into a 32-bit digit shifter and the value (zigzag
//   mapped for signed kinds) into a 64-bit one; each cycle in which the output
//   register is free, one byte leaves a shifter for it, key first, then value
//   (a payload item has no key). An item holds the block until its last byte
//   is emitted: up to 15 bytes for a 64-bit varint with a large field number,
//   none for an unknown kind; the output takes one byte per cycle unless the
//   receiver stalls.
//   o_stall is high while a run is being emitted; the next item is accepted
//   while the last byte of the previous run still waits in the output register.
//   A stalled receiver holds the output register and freezes the shifters.
//   Reset clears the sequencer and output valid; no bytes are pending after it.
module protobuf_field_encoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_kind,
    input  logic [28:0] i_field_number,
    input  logic [63:0] i_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last
);

    pbfe_pkg::t_state   r_state, n_state;
    logic               r_ov, n_ov;
    logic [7:0]         r_ob, n_ob;
    logic               r_ol, n_ol;

    logic               accept;
    logic               out_free;
    logic               key_shift, val_shift;
    logic               emit;
    logic [7:0]         emit_byte;
    logic               emit_last;
    logic [2:0]         wt;
    logic [pbfe_pkg::KEY_W-1:0]   key_word;
    logic [pbfe_pkg::VALUE_W-1:0] val_word;
    pbfe_pkg::t_sr_mode key_mode, val_mode;
    pbfe_pkg::t_sr_stat key_stat, val_stat;

    assign accept   = i_valid && !o_stall;
    assign out_free = !r_ov || !i_stall;

    // load-side word formatting
    always_comb begin
        wt       = pbfe_pkg::WT_VARINT;
        val_word = i_value;
        val_mode = '{raw: 1'b0, count: pbfe_pkg::CNT_ONE};
        case (i_kind)
            pbfe_pkg::K_SINT8: begin
                val_word = {56'd0, {i_value[6:0], 1'b0} ^ {8{i_value[7]}}};
            end
            pbfe_pkg::K_SINT16: begin
                val_word = {48'd0, {i_value[14:0], 1'b0} ^ {16{i_value[15]}}};
            end
            pbfe_pkg::K_SINT32: begin
                val_word = {32'd0, {i_value[30:0], 1'b0} ^ {32{i_value[31]}}};
            end
            pbfe_pkg::K_SINT64: begin
                val_word = {i_value[62:0], 1'b0} ^ {64{i_value[63]}};
            end
            pbfe_pkg::K_FIXED32: begin
                wt       = pbfe_pkg::WT_FIXED32;
                val_mode = '{raw: 1'b1, count: pbfe_pkg::CNT_FOUR};
            end
            pbfe_pkg::K_FIXED64: begin
                wt       = pbfe_pkg::WT_FIXED64;
                val_mode = '{raw: 1'b1, count: pbfe_pkg::CNT_EIGHT};
            end
            pbfe_pkg::K_LENHDR: begin
                wt = pbfe_pkg::WT_LENDELIM;
            end
            pbfe_pkg::K_PAYLOAD: begin
                val_mode = '{raw: 1'b1, count: pbfe_pkg::CNT_ONE};
            end
            default: begin
            end
        endcase
        key_word = {i_field_number, wt};
        key_mode = '{raw: 1'b0, count: pbfe_pkg::CNT_ONE};
    end

    pbfe_digit_sr #(.W(pbfe_pkg::KEY_W)) u_key_sr (
        .i_clk   (i_clk),
        .i_load  (accept),
        .i_data  (key_word),
        .i_mode  (key_mode),
        .i_shift (key_shift),
        .o_stat  (key_stat)
    );

    pbfe_digit_sr #(.W(pbfe_pkg::VALUE_W)) u_val_sr (
        .i_clk   (i_clk),
        .i_load  (accept),
        .i_data  (val_word),
        .i_mode  (val_mode),
        .i_shift (val_shift),
        .o_stat  (val_stat)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pbfe_pkg::ST_IDLE: begin
                if (i_valid) begin
                    if (i_kind == pbfe_pkg::K_PAYLOAD) begin
                        n_state = pbfe_pkg::ST_VAL;
                    end else if (i_kind inside {[pbfe_pkg::K_UVARINT:pbfe_pkg::K_LENHDR]}) begin
                        n_state = pbfe_pkg::ST_KEY;
                    end
                end
            end
            pbfe_pkg::ST_KEY: begin
                if (out_free && key_stat.done) begin
                    n_state = pbfe_pkg::ST_VAL;
                end
            end
            pbfe_pkg::ST_VAL: begin
                if (out_free && val_stat.done) begin
                    n_state = pbfe_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pbfe_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_stall   = 1'b1;
        key_shift = 1'b0;
        val_shift = 1'b0;
        emit      = 1'b0;
        emit_byte = key_stat.digit;
        emit_last = 1'b0;
        case (r_state)
            pbfe_pkg::ST_IDLE: begin
                o_stall = 1'b0;
            end
            pbfe_pkg::ST_KEY: begin
                key_shift = out_free;
                emit      = out_free;
            end
            pbfe_pkg::ST_VAL: begin
                val_shift = out_free;
                emit      = out_free;
                emit_byte = val_stat.digit;
                emit_last = val_stat.done;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_ov = r_ov;
        n_ob = r_ob;
        n_ol = r_ol;
        if (emit) begin
            n_ov = 1'b1;
            n_ob = emit_byte;
            n_ol = emit_last;
        end else if (!i_stall) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pbfe_pkg::ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ob <= n_ob;
        r_ol <= n_ol;
    end

    assign o_valid    = r_ov;
    assign o_out_byte = r_ob;
    assign o_last     = r_ol;

endmodule

// ----- rtl/pbfe_digit_sr.sv -----
// Digit shifter: holds a word and hands it out one byte per step, either as
// base-128 varint groups or as raw little-endian bytes. Depends on pbfe_pkg.
module pbfe_digit_sr #(
    parameter int unsigned W = 64
) (
    input  logic                i_clk,
    input  logic                i_load,
    input  logic [W-1:0]        i_data,
    input  pbfe_pkg::t_sr_mode  i_mode,
    input  logic                i_shift,
    output pbfe_pkg::t_sr_stat  o_stat
);

    logic [W-1:0]                r_data, n_data;
    logic                        r_raw, n_raw;
    logic [pbfe_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic                        more;

    always_comb begin
        if (r_raw) begin
            more         = (r_cnt != pbfe_pkg::CNT_ONE);
            o_stat.digit = r_data[7:0];
        end else begin
            more         = |r_data[W-1:7];
            o_stat.digit = {more, r_data[6:0] & pbfe_pkg::VARINT_MASK};
        end
        o_stat.done = !more;
    end

    always_comb begin
        n_data = r_data;
        n_raw  = r_raw;
        n_cnt  = r_cnt;
        if (i_load) begin
            n_data = i_data;
            n_raw  = i_mode.raw;
            n_cnt  = i_mode.count;
        end else if (i_shift) begin
            if (r_raw) begin
                n_data = {8'd0, r_data[W-1:8]};
                n_cnt  = r_cnt - pbfe_pkg::CNT_ONE;
            end else begin
                n_data = {7'd0, r_data[W-1:7]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_raw  <= n_raw;
        r_cnt  <= n_cnt;
    end

endmodule

// ----- rtl/pbfe_checker.sv -----
// Port-level checks for protobuf_field_encoder_core, bound to the top level.
// Depends on pbfe_pkg and the top level's ports.
module pbfe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [3:0]  i_kind,
    input logic [28:0] i_field_number,
    input logic [63:0] i_value,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_out_byte,
    input logic        o_last
);

    // a stalled byte stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte) && $stable(o_last))
        else $error("output item changed under stall");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // a run still in progress keeps the input side busy
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_stall)
        else $error("input taken in the middle of a run");

    a_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_kind == pbfe_pkg::K_PAYLOAD |=> o_stall)
        else $error("payload item did not start a run");

    a_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_kind > pbfe_pkg::K_PAYLOAD) |=> !o_stall)
        else $error("unknown kind started a run");

endmodule

bind protobuf_field_encoder_core pbfe_checker u_pbfe_checker (.*);
